@@ hdl/ale_pkg.sv @@
// Shared types, codes and widths for the array list engine.
package ale_pkg;

    localparam int DEPTH = 16;

    localparam int CNT_W = 5;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT    = 3'd4;
    localparam logic [OP_W-1:0] OP_SHOW    = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    // read address select
    localparam logic [1:0] RA_I   = 2'd0;
    localparam logic [1:0] RA_J   = 2'd1;
    localparam logic [1:0] RA_IP1 = 2'd2;
    localparam logic [1:0] RA_IM1 = 2'd3;

    // write address select
    localparam logic WA_I = 1'b0;
    localparam logic WA_J = 1'b1;

    // write data select
    localparam logic [1:0] WD_VAL  = 2'd0;
    localparam logic [1:0] WD_HOLD = 2'd1;
    localparam logic [1:0] WD_RD   = 2'd2;

    // index i update
    localparam logic [2:0] IOP_NONE  = 3'd0;
    localparam logic [2:0] IOP_ZERO  = 3'd1;
    localparam logic [2:0] IOP_CNT   = 3'd2;
    localparam logic [2:0] IOP_POSM1 = 3'd3;
    localparam logic [2:0] IOP_INC   = 3'd4;
    localparam logic [2:0] IOP_DEC   = 3'd5;

    // index j update
    localparam logic [2:0] JOP_NONE  = 3'd0;
    localparam logic [2:0] JOP_IP1   = 3'd1;
    localparam logic [2:0] JOP_CNTM1 = 3'd2;
    localparam logic [2:0] JOP_INC   = 3'd3;
    localparam logic [2:0] JOP_DEC   = 3'd4;

    // result data select
    localparam logic [1:0] DS_ZERO = 2'd0;
    localparam logic [1:0] DS_HOLD = 2'd1;
    localparam logic [1:0] DS_RD   = 2'd2;

    typedef struct packed {
        logic            capture;
        logic            rd_en;
        logic [1:0]      rd_sel;
        logic            wr_en;
        logic            wr_sel;
        logic [1:0]      wd_sel;
        logic [2:0]      i_op;
        logic [2:0]      j_op;
        logic            hold_ld;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            emit;
        logic [ST_W-1:0] em_status;
        logic [1:0]      em_dsel;
        logic            em_last;
    } ale_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            cnt_zero;
        logic            cnt_le1;
        logic            ins_bad;
        logic            del_bad;
        logic            i_ge_pos;
        logic            ip1_lt_cnt;
        logic            i_lt_j;
        logic            i_lt_cnt;
        logic            j_lt_cnt;
        logic            hold_gt_rd;
        logic            i_last;
        logic            out_free;
    } ale_sts_t;

endpackage

@@ hdl/array_list_engine_unit.sv @@
// Array list engine: a list of signed 32-bit values kept in an on-chip store, one request at a
// time. Requests are taken one at a time; s_tready is high only while the engine is idle.
// Every memory step goes through the store's single read port, whose data is registered, so
// insert and delete move each entry with a read and then a write, reverse reads both ends of
// a pair and then writes both, sort compares each pair (n*(n-1)/2 pairs) with a read of j
// and a conditional write, and show reads each element before emitting it.
// The result register lets the next request start while the last result waits. Capacity is
// set through the cfg channel; the user writes it only while the engine is idle, which the
// block itself does not enforce. The store needs no clearing after reset.
module array_list_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [4:0] position, [36:5] value, [39:37] zero
    input  logic [2:0]  s_tuser,  // [2:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] data, [36:32] count, [37] empty_flag,
                                  // [38] full_flag, [39] zero
    output logic [1:0]  m_tuser,  // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data  // capacity
);

    ale_pkg::ale_cmd_t cmd;
    ale_pkg::ale_sts_t sts;

    logic [ale_pkg::CNT_W-1:0]        out_count;
    logic signed [ale_pkg::VAL_W-1:0] out_data;
    logic                             out_empty;
    logic                             out_full;

    assign cfg_ready = 1'b1;

    ale_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ale_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (s_tuser),
        .in_pos     (s_tdata[4:0]),
        .in_val     (s_tdata[36:5]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_cap    (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (m_tuser),
        .out_data   (out_data),
        .out_count  (out_count),
        .out_empty  (out_empty),
        .out_full   (out_full),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_full, out_empty, out_count, out_data};

    // a new result never overwrites one still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result register overwritten");

    // the store is never written while the engine is idle
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.wr_en)
        else $error("store written while idle");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[37] == (m_tdata[36:32] == 5'd0)))
        else $error("empty flag disagrees with count");

    // any failure status comes as a single, final result
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ale_pkg::ST_OK)) |-> m_tlast)
        else $error("error result not marked last");

endmodule

@@ hdl/ale_ctrl.sv @@
// Sequencer for the array list engine: walks each request through its memory steps.
module ale_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ale_pkg::ale_sts_t sts,
    output ale_pkg::ale_cmd_t cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_APPEND   = 5'd2;
    localparam logic [4:0] S_INS_CHK  = 5'd3;
    localparam logic [4:0] S_INS_WR   = 5'd4;
    localparam logic [4:0] S_DEL_RD   = 5'd5;
    localparam logic [4:0] S_DEL_HOLD = 5'd6;
    localparam logic [4:0] S_DEL_CHK  = 5'd7;
    localparam logic [4:0] S_DEL_WR   = 5'd8;
    localparam logic [4:0] S_REV_CHK  = 5'd9;
    localparam logic [4:0] S_REV_RDJ  = 5'd10;
    localparam logic [4:0] S_REV_WRI  = 5'd11;
    localparam logic [4:0] S_REV_WRJ  = 5'd12;
    localparam logic [4:0] S_SRT_CHKI = 5'd13;
    localparam logic [4:0] S_SRT_LDI  = 5'd14;
    localparam logic [4:0] S_SRT_CHKJ = 5'd15;
    localparam logic [4:0] S_SRT_CMP  = 5'd16;
    localparam logic [4:0] S_SHW_RD   = 5'd17;
    localparam logic [4:0] S_SHW_EMIT = 5'd18;
    localparam logic [4:0] S_EMIT     = 5'd19;

    logic [4:0]              state_reg, state_next;
    logic [ale_pkg::ST_W-1:0] st_reg, st_next;
    logic [1:0]              dsel_reg, dsel_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        dsel_next  = dsel_reg;
        cmd        = '0;
        cmd.rd_sel = ale_pkg::RA_I;
        cmd.wr_sel = ale_pkg::WA_I;
        cmd.wd_sel = ale_pkg::WD_VAL;
        cmd.i_op   = ale_pkg::IOP_NONE;
        cmd.j_op   = ale_pkg::JOP_NONE;
        cmd.em_status = ale_pkg::ST_OK;
        cmd.em_dsel   = ale_pkg::DS_ZERO;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                st_next    = ale_pkg::ST_OK;
                dsel_next  = ale_pkg::DS_ZERO;
                state_next = S_EMIT;
                case (sts.op)
                    ale_pkg::OP_APPEND: begin
                        if (sts.full) begin
                            st_next = ale_pkg::ST_FULL;
                        end else begin
                            cmd.i_op   = ale_pkg::IOP_CNT;
                            state_next = S_APPEND;
                        end
                    end
                    ale_pkg::OP_INSERT: begin
                        if (sts.full) begin
                            st_next = ale_pkg::ST_FULL;
                        end else if (sts.ins_bad) begin
                            st_next = ale_pkg::ST_BADPOS;
                        end else begin
                            cmd.i_op   = ale_pkg::IOP_CNT;
                            state_next = S_INS_CHK;
                        end
                    end
                    ale_pkg::OP_DELETE: begin
                        if (sts.cnt_zero) begin
                            st_next = ale_pkg::ST_EMPTY;
                        end else if (sts.del_bad) begin
                            st_next = ale_pkg::ST_BADPOS;
                        end else begin
                            cmd.i_op   = ale_pkg::IOP_POSM1;
                            state_next = S_DEL_RD;
                        end
                    end
                    ale_pkg::OP_REVERSE: begin
                        if (!sts.cnt_le1) begin
                            cmd.i_op   = ale_pkg::IOP_ZERO;
                            cmd.j_op   = ale_pkg::JOP_CNTM1;
                            state_next = S_REV_CHK;
                        end
                    end
                    ale_pkg::OP_SORT: begin
                        cmd.i_op   = ale_pkg::IOP_ZERO;
                        state_next = S_SRT_CHKI;
                    end
                    ale_pkg::OP_SHOW: begin
                        if (sts.cnt_zero) begin
                            st_next = ale_pkg::ST_EMPTY;
                        end else begin
                            cmd.i_op   = ale_pkg::IOP_ZERO;
                            state_next = S_SHW_RD;
                        end
                    end
                    default: begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_APPEND: begin
                cmd.wr_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_EMIT;
            end
            // shift entries up from the top until the hole reaches pos-1
            S_INS_CHK: begin
                if (sts.i_ge_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ale_pkg::RA_IM1;
                    state_next = S_INS_WR;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = ale_pkg::WD_RD;
                cmd.i_op   = ale_pkg::IOP_DEC;
                state_next = S_INS_CHK;
            end
            S_DEL_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_DEL_HOLD;
            end
            S_DEL_HOLD: begin
                cmd.hold_ld = 1'b1;
                state_next  = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (sts.ip1_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ale_pkg::RA_IP1;
                    state_next = S_DEL_WR;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    dsel_next   = ale_pkg::DS_HOLD;
                    state_next  = S_EMIT;
                end
            end
            S_DEL_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = ale_pkg::WD_RD;
                cmd.i_op   = ale_pkg::IOP_INC;
                state_next = S_DEL_CHK;
            end
            S_REV_CHK: begin
                if (sts.i_lt_j) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_REV_RDJ;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_REV_RDJ: begin
                cmd.hold_ld = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = ale_pkg::RA_J;
                state_next  = S_REV_WRI;
            end
            S_REV_WRI: begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = ale_pkg::WD_RD;
                state_next = S_REV_WRJ;
            end
            S_REV_WRJ: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = ale_pkg::WA_J;
                cmd.wd_sel = ale_pkg::WD_HOLD;
                cmd.i_op   = ale_pkg::IOP_INC;
                cmd.j_op   = ale_pkg::JOP_DEC;
                state_next = S_REV_CHK;
            end
            // hold carries the running minimum for slot i
            S_SRT_CHKI: begin
                if (sts.i_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.j_op   = ale_pkg::JOP_IP1;
                    state_next = S_SRT_LDI;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_SRT_LDI: begin
                cmd.hold_ld = 1'b1;
                state_next  = S_SRT_CHKJ;
            end
            S_SRT_CHKJ: begin
                if (sts.j_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ale_pkg::RA_J;
                    state_next = S_SRT_CMP;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wd_sel = ale_pkg::WD_HOLD;
                    cmd.i_op   = ale_pkg::IOP_INC;
                    state_next = S_SRT_CHKI;
                end
            end
            S_SRT_CMP: begin
                if (sts.hold_gt_rd) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = ale_pkg::WA_J;
                    cmd.wd_sel  = ale_pkg::WD_HOLD;
                    cmd.hold_ld = 1'b1;
                end
                cmd.j_op   = ale_pkg::JOP_INC;
                state_next = S_SRT_CHKJ;
            end
            S_SHW_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_SHW_EMIT;
            end
            S_SHW_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.em_dsel = ale_pkg::DS_RD;
                    cmd.em_last = sts.i_last;
                    if (sts.i_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.i_op   = ale_pkg::IOP_INC;
                        state_next = S_SHW_RD;
                    end
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.em_status = st_reg;
                    cmd.em_dsel   = dsel_reg;
                    cmd.em_last   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ale_pkg::ST_OK;
            dsel_reg  <= ale_pkg::DS_ZERO;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            dsel_reg  <= dsel_next;
        end
    end

endmodule

@@ hdl/ale_dpath.sv @@
// Datapath of the array list engine: element store, indices, count and result register.
module ale_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ale_pkg::OP_W-1:0]      in_op,
    input  logic [ale_pkg::POS_W-1:0]     in_pos,
    input  logic signed [ale_pkg::VAL_W-1:0] in_val,
    input  logic                          cfg_we,
    input  logic [ale_pkg::CAP_W-1:0]     cfg_cap,
    input  ale_pkg::ale_cmd_t             cmd,
    output ale_pkg::ale_sts_t             sts,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ale_pkg::ST_W-1:0]      out_status,
    output logic signed [ale_pkg::VAL_W-1:0] out_data,
    output logic [ale_pkg::CNT_W-1:0]     out_count,
    output logic                          out_empty,
    output logic                          out_full,
    output logic                          out_last
);

    localparam int DEPTH = ale_pkg::DEPTH;
    localparam int AW = $clog2(DEPTH);

    logic signed [ale_pkg::VAL_W-1:0] elem_mem [DEPTH];

    logic [ale_pkg::OP_W-1:0]         op_reg;
    logic [ale_pkg::POS_W-1:0]        pos_reg;
    logic signed [ale_pkg::VAL_W-1:0] val_reg;
    logic [ale_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ale_pkg::CAP_W-1:0]        cap_reg;
    logic [ale_pkg::CNT_W-1:0]        i_reg, i_next;
    logic [ale_pkg::CNT_W-1:0]        j_reg, j_next;
    logic signed [ale_pkg::VAL_W-1:0] hold_reg;
    logic signed [ale_pkg::VAL_W-1:0] rd_data_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [ale_pkg::ST_W-1:0]         out_status_reg;
    logic signed [ale_pkg::VAL_W-1:0] out_data_reg;
    logic [ale_pkg::CNT_W-1:0]        out_count_reg;
    logic                             out_empty_reg;
    logic                             out_full_reg;
    logic                             out_last_reg;

    logic [ale_pkg::CNT_W-1:0]        rd_idx, wr_idx;
    logic [AW-1:0]                    rd_addr, wr_addr;
    logic signed [ale_pkg::VAL_W-1:0] wr_data, em_data;
    logic [ale_pkg::CAP_W-1:0]        eff_cap;
    logic                             full;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = ale_pkg::CAP_W'(1);
        end else if (int'(cap_reg) > DEPTH) begin
            eff_cap = ale_pkg::CAP_W'(DEPTH);
        end else begin
            eff_cap = cap_reg;
        end
    end

    // a capacity lowered below the count still reads as full
    assign full = (cnt_reg >= eff_cap);

    always_comb begin
        case (cmd.rd_sel)
            ale_pkg::RA_I:   rd_idx = i_reg;
            ale_pkg::RA_J:   rd_idx = j_reg;
            ale_pkg::RA_IP1: rd_idx = i_reg + ale_pkg::CNT_W'(1);
            ale_pkg::RA_IM1: rd_idx = i_reg - ale_pkg::CNT_W'(1);
            default:         rd_idx = i_reg;
        endcase
        wr_idx = (cmd.wr_sel == ale_pkg::WA_J) ? j_reg : i_reg;
        case (cmd.wd_sel)
            ale_pkg::WD_VAL:  wr_data = val_reg;
            ale_pkg::WD_HOLD: wr_data = hold_reg;
            ale_pkg::WD_RD:   wr_data = rd_data_reg;
            default:          wr_data = val_reg;
        endcase
        case (cmd.em_dsel)
            ale_pkg::DS_HOLD: em_data = hold_reg;
            ale_pkg::DS_RD:   em_data = rd_data_reg;
            default:          em_data = '0;
        endcase
    end

    assign rd_addr = AW'(rd_idx);
    assign wr_addr = AW'(wr_idx);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            elem_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= elem_mem[rd_addr];
        end
    end

    always_comb begin
        case (cmd.i_op)
            ale_pkg::IOP_ZERO:  i_next = '0;
            ale_pkg::IOP_CNT:   i_next = cnt_reg;
            ale_pkg::IOP_POSM1: i_next = pos_reg - ale_pkg::CNT_W'(1);
            ale_pkg::IOP_INC:   i_next = i_reg + ale_pkg::CNT_W'(1);
            ale_pkg::IOP_DEC:   i_next = i_reg - ale_pkg::CNT_W'(1);
            default:            i_next = i_reg;
        endcase
        case (cmd.j_op)
            ale_pkg::JOP_IP1:   j_next = i_reg + ale_pkg::CNT_W'(1);
            ale_pkg::JOP_CNTM1: j_next = cnt_reg - ale_pkg::CNT_W'(1);
            ale_pkg::JOP_INC:   j_next = j_reg + ale_pkg::CNT_W'(1);
            ale_pkg::JOP_DEC:   j_next = j_reg - ale_pkg::CNT_W'(1);
            default:            j_next = j_reg;
        endcase
        cnt_next = cnt_reg;
        if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + ale_pkg::CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - ale_pkg::CNT_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            cap_reg       <= ale_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_cap;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        if (cmd.capture) begin
            op_reg  <= in_op;
            pos_reg <= in_pos;
            val_reg <= in_val;
        end
        if (cmd.hold_ld) begin
            hold_reg <= rd_data_reg;
        end
        if (cmd.emit) begin
            out_status_reg <= cmd.em_status;
            out_data_reg   <= em_data;
            out_count_reg  <= cnt_reg;
            out_empty_reg  <= (cnt_reg == '0);
            out_full_reg   <= full;
            out_last_reg   <= cmd.em_last;
        end
    end

    always_comb begin
        sts.op         = op_reg;
        sts.full       = full;
        sts.cnt_zero   = (cnt_reg == '0);
        sts.cnt_le1    = (cnt_reg <= ale_pkg::CNT_W'(1));
        sts.ins_bad    = (pos_reg == '0) ||
                         ({1'b0, pos_reg} > ({1'b0, cnt_reg} + 6'd1));
        sts.del_bad    = (pos_reg == '0) || (pos_reg > cnt_reg);
        sts.i_ge_pos   = (i_reg >= pos_reg);
        sts.ip1_lt_cnt = (({1'b0, i_reg} + 6'd1) < {1'b0, cnt_reg});
        sts.i_lt_j     = (i_reg < j_reg);
        sts.i_lt_cnt   = (i_reg < cnt_reg);
        sts.j_lt_cnt   = (j_reg < cnt_reg);
        sts.hold_gt_rd = (hold_reg > rd_data_reg);
        sts.i_last     = (({1'b0, i_reg} + 6'd1) == {1'b0, cnt_reg});
        sts.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid   = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_count  = out_count_reg;
    assign out_empty  = out_empty_reg;
    assign out_full   = out_full_reg;
    assign out_last   = out_last_reg;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the array list engine: directed, capacity, random and stall tests.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH       = ale_pkg::DEPTH;
    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 8;
    localparam int END_SETTLE  = 50;
    localparam int MAX_REPORTS = 10;

    // op codes the block treats as no-ops
    localparam logic [ale_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [ale_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    typedef struct packed {
        logic [ale_pkg::ST_W-1:0]  status;
        logic [ale_pkg::VAL_W-1:0] data;
        logic [ale_pkg::CNT_W-1:0] count;
        logic                      empty_flag;
        logic                      full_flag;
        logic                      last;
    } list_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    // shadow copy of the list
    logic [ale_pkg::VAL_W-1:0] shadow_list [DEPTH];
    int               shadow_count = 0;
    int               shadow_cap   = int'(ale_pkg::CAP_RESET);
    list_result_t     pending_results [$];

    int err_count      = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int burst_left     = 1;
    int hold_off_req   = 0;
    int op_hits [8];

    array_list_engine_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic logic list_at_capacity();
        int limit;
        limit = (shadow_cap == 0) ? 1 : ((shadow_cap > DEPTH) ? DEPTH : shadow_cap);
        return shadow_count >= limit;
    endfunction

    function automatic void push_result(logic [ale_pkg::ST_W-1:0] status,
                                        logic [ale_pkg::VAL_W-1:0] data, logic last);
        list_result_t r;
        r.status     = status;
        r.data       = data;
        r.count      = shadow_count[ale_pkg::CNT_W-1:0];
        r.empty_flag = (shadow_count == 0);
        r.full_flag  = list_at_capacity();
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_list_op(logic [ale_pkg::OP_W-1:0] op,
                                          logic [ale_pkg::POS_W-1:0] pos,
                                          logic [ale_pkg::VAL_W-1:0] val);
        int i;
        int j;
        int p;
        logic [ale_pkg::VAL_W-1:0] t;
        p = int'(pos);
        case (op)
            ale_pkg::OP_APPEND: begin
                if (list_at_capacity()) begin
                    push_result(ale_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    shadow_list[shadow_count] = val;
                    shadow_count++;
                    push_result(ale_pkg::ST_OK, '0, 1'b1);
                end
            end
            ale_pkg::OP_INSERT: begin
                if (list_at_capacity()) begin
                    push_result(ale_pkg::ST_FULL, '0, 1'b1);
                end else if (p < 1 || p > shadow_count + 1) begin
                    push_result(ale_pkg::ST_BADPOS, '0, 1'b1);
                end else begin
                    for (i = shadow_count; i > p - 1; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p-1] = val;
                    shadow_count++;
                    push_result(ale_pkg::ST_OK, '0, 1'b1);
                end
            end
            ale_pkg::OP_DELETE: begin
                if (shadow_count == 0) begin
                    push_result(ale_pkg::ST_EMPTY, '0, 1'b1);
                end else if (p < 1 || p > shadow_count) begin
                    push_result(ale_pkg::ST_BADPOS, '0, 1'b1);
                end else begin
                    t = shadow_list[p-1];
                    for (i = p - 1; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    push_result(ale_pkg::ST_OK, t, 1'b1);
                end
            end
            ale_pkg::OP_REVERSE: begin
                for (i = 0; i < shadow_count / 2; i++) begin
                    t = shadow_list[i];
                    shadow_list[i] = shadow_list[shadow_count-1-i];
                    shadow_list[shadow_count-1-i] = t;
                end
                push_result(ale_pkg::ST_OK, '0, 1'b1);
            end
            ale_pkg::OP_SORT: begin
                for (i = 0; i < shadow_count; i++) begin
                    for (j = i + 1; j < shadow_count; j++) begin
                        if ($signed(shadow_list[i]) > $signed(shadow_list[j])) begin
                            t = shadow_list[i];
                            shadow_list[i] = shadow_list[j];
                            shadow_list[j] = t;
                        end
                    end
                end
                push_result(ale_pkg::ST_OK, '0, 1'b1);
            end
            ale_pkg::OP_SHOW: begin
                if (shadow_count == 0) begin
                    push_result(ale_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        push_result(ale_pkg::ST_OK, shadow_list[i], i + 1 == shadow_count);
                end
            end
            default: push_result(ale_pkg::ST_OK, '0, 1'b1);
        endcase
    endfunction

    // ---------------- checking ----------------

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                shadow_cap = int'(cfg_data);
            if (s_tvalid && s_tready)
                apply_list_op(s_tuser, s_tdata[4:0], s_tdata[36:5]);
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.status     = m_tuser;
                got.data       = m_tdata[31:0];
                got.count      = m_tdata[36:32];
                got.empty_flag = m_tdata[37];
                got.full_flag  = m_tdata[38];
                got.last       = m_tlast;
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: status=%0d data=%h",
                                 $realtime, got.status, got.data);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.count !== want.count || got.empty_flag !== want.empty_flag ||
                        got.full_flag !== want.full_flag || got.last !== want.last) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch on result %0d", $realtime, results_seen);
                            $display("  want status=%0d data=%h count=%0d empty=%0b full=%0b last=%0b",
                                     want.status, want.data, want.count, want.empty_flag,
                                     want.full_flag, want.last);
                            $display("  got  status=%0d data=%h count=%0d empty=%0b full=%0b last=%0b",
                                     got.status, got.data, got.count, got.empty_flag,
                                     got.full_flag, got.last);
                        end
                    end
                end
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin : rx_ready_gen
        rx_mode_t mode;
        int left;
        int phase;
        int hold;
        mode  = RX_STEADY;
        left  = 0;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req > 0) begin
                // long hold-off so the engine backs up into its input
                hold = hold_off_req;
                hold_off_req = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 120);
            end
            left--;
            phase++;
            case (mode)
                RX_STEADY:   m_tready <= 1'b1;
                RX_COIN:     m_tready <= ($urandom_range(0, 1) != 0);
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_tready <= ((phase % 5) < 2);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    // ---------------- sender ----------------

    task automatic send_request(input logic [ale_pkg::OP_W-1:0] op,
                                input logic [ale_pkg::POS_W-1:0] pos,
                                input logic [ale_pkg::VAL_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, val, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        op_hits[op]++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [ale_pkg::CAP_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ale_pkg::VAL_W-1:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20) - 10;
            1: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'h0000_0000;
                   default: return 32'hffff_ffff;
               endcase
            default: return $urandom;
        endcase
    endfunction

    // mostly in-range positions, some anywhere in the field
    function automatic logic [ale_pkg::POS_W-1:0] random_position(input int top);
        if ($urandom_range(0, 4) == 0 || top < 1)
            return ale_pkg::POS_W'($urandom_range(0, 31));
        return ale_pkg::POS_W'($urandom_range(1, top));
    endfunction

    // returns 1 when the op is one the block acts on
    task automatic random_request(input int append_w, output logic counted);
        int r;
        logic [ale_pkg::OP_W-1:0] op;
        r = $urandom_range(0, append_w + 60);
        if (r < append_w)            op = ale_pkg::OP_APPEND;
        else if (r < append_w + 20)  op = ale_pkg::OP_INSERT;
        else if (r < append_w + 40)  op = ale_pkg::OP_DELETE;
        else if (r < append_w + 45)  op = ale_pkg::OP_REVERSE;
        else if (r < append_w + 50)  op = ale_pkg::OP_SORT;
        else if (r < append_w + 58)  op = ale_pkg::OP_SHOW;
        else                         op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        case (op)
            ale_pkg::OP_INSERT:
                send_request(op, random_position(shadow_count + 1), random_value());
            ale_pkg::OP_DELETE:
                send_request(op, random_position(shadow_count), random_value());
            default:
                send_request(op, ale_pkg::POS_W'($urandom_range(0, 31)), random_value());
        endcase
        counted = (op != OP_SPARE6 && op != OP_SPARE7);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_ops();
        send_request(ale_pkg::OP_SHOW,    5'd0,  32'h0);           // show on empty
        send_request(ale_pkg::OP_DELETE,  5'd1,  32'h0);           // delete on empty
        send_request(ale_pkg::OP_REVERSE, 5'd0,  32'h0);
        send_request(ale_pkg::OP_SORT,    5'd0,  32'h0);
        send_request(ale_pkg::OP_APPEND,  5'd0,  32'h7fff_ffff);
        send_request(ale_pkg::OP_APPEND,  5'd31, 32'h8000_0000);
        send_request(ale_pkg::OP_INSERT,  5'd1,  32'hffff_ffff);
        send_request(ale_pkg::OP_INSERT,  5'd4,  32'h0000_0000);   // at count+1
        send_request(ale_pkg::OP_INSERT,  5'd0,  32'h1234_5678);   // position zero
        send_request(ale_pkg::OP_INSERT,  5'd6,  32'h1234_5678);   // past count+1
        send_request(ale_pkg::OP_INSERT,  5'd31, 32'h5555_aaaa);
        send_request(ale_pkg::OP_DELETE,  5'd0,  32'h0);
        send_request(ale_pkg::OP_DELETE,  5'd5,  32'h0);           // past count
        send_request(ale_pkg::OP_SORT,    5'd0,  32'h0);
        send_request(ale_pkg::OP_SHOW,    5'd0,  32'h0);
        send_request(ale_pkg::OP_REVERSE, 5'd0,  32'h0);
        send_request(ale_pkg::OP_SHOW,    5'd0,  32'h0);
        send_request(ale_pkg::OP_DELETE,  5'd1,  32'h0);
        send_request(ale_pkg::OP_DELETE,  5'd3,  32'h0);           // last entry
        send_request(OP_SPARE6,           5'd17, 32'hdead_beef);
        send_request(OP_SPARE7,           5'd2,  32'hffff_ffff);
        send_request(ale_pkg::OP_SHOW,    5'd0,  32'h0);
        wait_idle(SETTLE);
    endtask

    task automatic test_capacity_edges();
        write_capacity(5'd0);                             // acts as one
        send_request(ale_pkg::OP_APPEND, 5'd0, 32'h0000_0001);
        send_request(ale_pkg::OP_INSERT, 5'd1, 32'h0000_0002);
        wait_idle(SETTLE);
        write_capacity(5'd31);                            // clamps to DEPTH
        send_request(ale_pkg::OP_APPEND, 5'd0, 32'h0000_0003);
        send_request(ale_pkg::OP_SHOW,   5'd0, 32'h0);
        wait_idle(SETTLE);
    endtask

    task automatic test_random_phase(input logic [ale_pkg::CAP_W-1:0] cap, input int n_items,
                                     input int append_w);
        int done;
        logic counted;
        done = 0;
        write_capacity(cap);
        while (done < n_items) begin
            random_request(append_w, counted);
            if (counted) done++;
        end
        wait_idle(SETTLE);
    endtask

    task automatic test_backpressure();
        int k;
        write_capacity(5'd16);
        hold_off_req = 400;
        burst_left   = 1000;                              // no sender gaps here
        for (k = 0; k < 4; k++)
            send_request(ale_pkg::OP_APPEND, 5'd0, random_value());
        for (k = 0; k < 3; k++)
            send_request(ale_pkg::OP_SHOW, 5'd0, 32'h0);
        send_request(ale_pkg::OP_SORT, 5'd0, 32'h0);
        send_request(ale_pkg::OP_SHOW, 5'd0, 32'h0);
        send_request(ale_pkg::OP_SHOW, 5'd0, 32'h0);
        burst_left = 1;
        wait_idle(END_SETTLE);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_capacity_edges();
        test_random_phase(5'd16, 46, 50);
        test_random_phase(5'd3,  46, 25);                 // below the current count
        test_random_phase(5'd1,  46, 30);
        test_random_phase(5'd12, 46, 35);
        test_random_phase(5'd16, 46, 20);
        test_backpressure();

        $display("covered %0d append, %0d insert, %0d delete, %0d reverse, %0d sort, %0d show",
                 op_hits[ale_pkg::OP_APPEND], op_hits[ale_pkg::OP_INSERT],
                 op_hits[ale_pkg::OP_DELETE], op_hits[ale_pkg::OP_REVERSE],
                 op_hits[ale_pkg::OP_SORT], op_hits[ale_pkg::OP_SHOW]);
        $display("plus %0d no-op requests; %0d results checked, %0d left pending, %0d errors",
                 op_hits[OP_SPARE6] + op_hits[OP_SPARE7], results_seen,
                 pending_results.size(), err_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
